@@ sv/gcd_pkg.sv @@
// Shared constants and width helpers for the Gauss code crossing delete block.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package gcd_pkg;

	// Default sizing of the block
	localparam int unsigned MAX_CROSSINGS_DEF = 1024;
	localparam int unsigned PAYLOAD_BITS_DEF  = 2;

	// Depth of the result queue; an item is processed only with two free slots
	localparam int unsigned RES_DEPTH = 4;

	// Bits of a crossing index (at least one)
	function automatic int unsigned cross_w(input int unsigned max_crossings);
		int unsigned w;
		w = (max_crossings > 1) ? $clog2(max_crossings) : 1;
		return w;
	endfunction

	// Bits of the crossings-left count (holds max_crossings itself)
	function automatic int unsigned left_w(input int unsigned max_crossings);
		int unsigned w;
		w = $clog2(max_crossings + 1);
		return w;
	endfunction

endpackage : gcd_pkg

`default_nettype wire

@@ sv/gcd_entry_proc.sv @@
// Input register, deleted-crossing register and per-entry renumber logic.
// Depends on gcd_pkg; produces up to two packed results per item.
`default_nettype none

module gcd_entry_proc
	import gcd_pkg::*;
#(
	parameter int unsigned MAX_CROSSINGS = MAX_CROSSINGS_DEF,
	parameter int unsigned PAYLOAD_BITS  = PAYLOAD_BITS_DEF,
	localparam int unsigned CW = cross_w(MAX_CROSSINGS),
	localparam int unsigned LW = left_w(MAX_CROSSINGS),
	localparam int unsigned RW = CW + PAYLOAD_BITS + 2 + LW
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [CW-1:0]           cfg_data,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [CW-1:0]           entry_crossing,
	input  wire logic [PAYLOAD_BITS-1:0] entry_payload,
	input  wire logic                    entry_last,
	input  wire logic                    room,
	output logic [1:0]                   push_num,
	output logic [RW-1:0]                res0,
	output logic [RW-1:0]                res1
);

	localparam int unsigned KW = LW + 1;
	localparam logic [KW-1:0] KEPT_MAX = KW'(2 * MAX_CROSSINGS);

	logic [CW-1:0]           deleted_q;
	logic                    valid_s1;
	logic [CW-1:0]           crossing_s1;
	logic [PAYLOAD_BITS-1:0] payload_s1;
	logic                    last_s1;
	logic [CW-1:0]           held_cross_q;
	logic [PAYLOAD_BITS-1:0] held_pay_q;
	logic                    held_valid_q;
	logic [KW-1:0]           kept_q;

	logic                    proc;
	logic                    keep;
	logic [CW-1:0]           new_cross;
	logic                    emit_held;
	logic [CW-1:0]           held_cross_nx;
	logic [PAYLOAD_BITS-1:0] held_pay_nx;
	logic                    held_valid_nx;
	logic [KW-1:0]           kept_nx;
	logic [KW-1:0]           kept_inc;
	logic [LW-1:0]           left;
	logic [RW-1:0]           res_held;
	logic [RW-1:0]           res_final;

	// Deleted crossing register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deleted_q <= '0;
		end else if (cfg_we) begin
			deleted_q <= cfg_data;
		end
	end

	// Input stage takes a new item whenever the current one moves on
	assign proc     = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			crossing_s1 <= entry_crossing;
			payload_s1  <= entry_payload;
			last_s1     <= entry_last;
		end
	end

	// Match, renumber and next hold state
	always_comb begin
		keep          = crossing_s1 != deleted_q;
		new_cross     = (crossing_s1 > deleted_q) ? crossing_s1 - CW'(1) : crossing_s1;
		emit_held     = keep && held_valid_q;
		held_cross_nx = keep ? new_cross : held_cross_q;
		held_pay_nx   = keep ? payload_s1 : held_pay_q;
		held_valid_nx = keep || held_valid_q;
		kept_nx       = (keep && (kept_q < KEPT_MAX)) ? kept_q + KW'(1) : kept_q;
		kept_inc      = kept_nx + KW'(1);
		left          = kept_inc[KW-1:1];
		res_held      = {held_cross_q, held_pay_q, 1'b1, 1'b0, {LW{1'b0}}};
		if (held_valid_nx) begin
			res_final = {held_cross_nx, held_pay_nx, 1'b1, 1'b1, left};
		end else begin
			res_final = {{CW{1'b0}}, {PAYLOAD_BITS{1'b0}}, 1'b0, 1'b1, left};
		end
		// Slot order: held entry first, then the closing result
		res0 = emit_held ? res_held : res_final;
		res1 = res_final;
		if (!proc) begin
			push_num = 2'd0;
		end else begin
			push_num = {1'b0, emit_held} + {1'b0, last_s1};
		end
	end

	// Hold register and kept counter, cleared at the end of a code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			kept_q       <= '0;
		end else if (proc) begin
			held_valid_q <= held_valid_nx && !last_s1;
			kept_q       <= last_s1 ? '0 : kept_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			held_cross_q <= held_cross_nx;
			held_pay_q   <= held_pay_nx;
		end
	end

endmodule : gcd_entry_proc

`default_nettype wire

@@ sv/gcd_out_queue.sv @@
// Small result queue: takes up to two results a cycle, gives one a cycle while out_ready is high.
// Depends on gcd_pkg for its depth.
`default_nettype none

module gcd_out_queue
	import gcd_pkg::*;
#(
	parameter int unsigned RW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [1:0]    push_num,
	input  wire logic [RW-1:0] res0,
	input  wire logic [RW-1:0] res1,
	output logic               room,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [RW-1:0]      out_res
);

	localparam int unsigned AW = $clog2(RES_DEPTH);
	localparam int unsigned NW = AW + 1;

	logic [RW-1:0] slot_q [RES_DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [NW-1:0] cnt_q;
	logic          pop;
	logic [AW-1:0] wr_nx;

	assign out_valid = cnt_q != '0;
	assign pop       = out_valid && out_ready;
	assign room      = cnt_q <= NW'(RES_DEPTH - 2);
	assign out_res   = slot_q[rd_q];
	assign wr_nx     = wr_q + AW'(1);

	// Slot writes
	always_ff @(posedge clk) begin
		if (push_num != 2'd0) begin
			slot_q[wr_q] <= res0;
		end
		if (push_num == 2'd2) begin
			slot_q[wr_nx] <= res1;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + AW'(push_num);
			rd_q  <= rd_q + AW'(pop);
			cnt_q <= cnt_q + NW'(push_num) - NW'(pop);
		end
	end

endmodule : gcd_out_queue

`default_nettype wire

@@ sv/gauss_code_crossing_delete.sv @@
// Top level of the Gauss code crossing delete block.
// Depends on gcd_pkg, gcd_entry_proc and gcd_out_queue.
//
//   channel   signals                                        direction
//   config    cfg_we, cfg_data                                in
//   entry     in_valid/in_ready, entry_crossing/payload/last  in
//   result    out_valid/out_ready, out_crossing, out_payload,
//             is_entry, out_last, crossings_left              out
//
// One entry per cycle while the result queue has room; the results an entry
// causes pass through the input register, then the result queue. A kept entry
// is itself held back until the next kept entry or the end of its code pushes
// it out. The last entry of a code may yield two results, and the output port
// moves one result a cycle while out_ready is high. A four-slot result queue
// decouples the sides: the input register advances while at least two slots
// are free. Reset clears the hold state, the kept count, the queue and the
// deleted crossing; no clearing pass is needed.
`default_nettype none

module gauss_code_crossing_delete
	import gcd_pkg::*;
#(
	parameter int unsigned MAX_CROSSINGS = MAX_CROSSINGS_DEF,
	parameter int unsigned PAYLOAD_BITS  = PAYLOAD_BITS_DEF,
	localparam int unsigned CW = cross_w(MAX_CROSSINGS),
	localparam int unsigned LW = left_w(MAX_CROSSINGS)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [CW-1:0]           cfg_data,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [CW-1:0]           entry_crossing,
	input  wire logic [PAYLOAD_BITS-1:0] entry_payload,
	input  wire logic                    entry_last,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [CW-1:0]                out_crossing,
	output logic [PAYLOAD_BITS-1:0]      out_payload,
	output logic                         is_entry,
	output logic                         out_last,
	output logic [LW-1:0]                crossings_left
);

	localparam int unsigned RW = CW + PAYLOAD_BITS + 2 + LW;

	logic          room;
	logic [1:0]    push_num;
	logic [RW-1:0] res0;
	logic [RW-1:0] res1;
	logic [RW-1:0] out_res;

	// Per-entry processing
	gcd_entry_proc #(
		.MAX_CROSSINGS(MAX_CROSSINGS),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_proc (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.entry_crossing(entry_crossing),
		.entry_payload (entry_payload),
		.entry_last    (entry_last),
		.room          (room),
		.push_num      (push_num),
		.res0          (res0),
		.res1          (res1)
	);

	// Result queue
	gcd_out_queue #(
		.RW(RW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_num (push_num),
		.res0     (res0),
		.res1     (res1),
		.room     (room),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_res  (out_res)
	);

	// Unpack the result item
	assign {out_crossing, out_payload, is_entry, out_last, crossings_left} = out_res;

endmodule : gauss_code_crossing_delete

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for gauss_code_crossing_delete: directed and random Gauss codes,
// checked against an in-bench predictor. Depends on gcd_pkg and the block RTL.

module testbench
	import gcd_pkg::*;
();

	localparam int unsigned CW = cross_w(MAX_CROSSINGS_DEF);
	localparam int unsigned LW = left_w(MAX_CROSSINGS_DEF);
	localparam int unsigned PW = PAYLOAD_BITS_DEF;
	localparam int unsigned KEPT_SAT = 2 * MAX_CROSSINGS_DEF;
	localparam logic [CW-1:0] TOP_INDEX = '1;

	// one result item as the block should present it
	typedef struct packed {
		logic [CW-1:0] crossing;
		logic [PW-1:0] payload;
		logic          is_entry;
		logic          last;
		logic [LW-1:0] left;
	} gauss_out_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          cfg_we = 1'b0;
	logic [CW-1:0] cfg_data = '0;
	logic          in_valid = 1'b0;
	logic          in_ready;
	logic [CW-1:0] entry_crossing = '0;
	logic [PW-1:0] entry_payload = '0;
	logic          entry_last = 1'b0;
	logic          out_valid;
	logic          out_ready = 1'b0;
	logic [CW-1:0] out_crossing;
	logic [PW-1:0] out_payload;
	logic          is_entry;
	logic          out_last;
	logic [LW-1:0] crossings_left;

	// predictor state: deleted crossing, held entry, kept count
	logic [CW-1:0] model_deleted = '0;
	logic [CW-1:0] held_crossing = '0;
	logic [PW-1:0] held_payload = '0;
	logic          held_valid = 1'b0;
	int unsigned   kept_count = 0;

	gauss_out_t gauss_out_q[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int err_count = 0;
	int entries_sent = 0;
	int codes_sent = 0;
	int results_checked = 0;
	int deleted_settings = 0;

	gauss_code_crossing_delete DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.entry_crossing (entry_crossing),
		.entry_payload  (entry_payload),
		.entry_last     (entry_last),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_crossing   (out_crossing),
		.out_payload    (out_payload),
		.is_entry       (is_entry),
		.out_last       (out_last),
		.crossings_left (crossings_left)
	);

	always #6 clk = ~clk;

	// Predict the results of one accepted entry
	task automatic delete_step(input logic [CW-1:0] c, input logic [PW-1:0] p,
			input logic l);
		gauss_out_t r;
		logic [LW-1:0] left;
		if (c != model_deleted) begin
			if (held_valid) begin
				r = '{held_crossing, held_payload, 1'b1, 1'b0, '0};
				gauss_out_q.push_back(r);
			end
			held_crossing = (c > model_deleted) ? c - 1'b1 : c;
			held_payload = p;
			held_valid = 1'b1;
			if (kept_count < KEPT_SAT)
				kept_count++;
		end
		if (l) begin
			left = LW'((kept_count + 1) >> 1);
			if (held_valid)
				r = '{held_crossing, held_payload, 1'b1, 1'b1, left};
			else
				r = '{'0, '0, 1'b0, 1'b1, left};
			gauss_out_q.push_back(r);
			held_valid = 1'b0;
			held_crossing = '0;
			held_payload = '0;
			kept_count = 0;
		end
	endtask

	// Register writes and accepted entries feed the predictor
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				model_deleted = cfg_data;
			if (in_valid && in_ready)
				delete_step(entry_crossing, entry_payload, entry_last);
		end
	end

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		gauss_out_t e;
		if (arst_n && out_valid && out_ready) begin
			results_checked++;
			if (gauss_out_q.size() == 0) begin
				$error("unexpected result: crossing %0d last %0b", out_crossing, out_last);
				err_count++;
			end else begin
				e = gauss_out_q.pop_front();
				if (out_crossing !== e.crossing) begin
					$error("out_crossing: expected %0d, got %0d", e.crossing, out_crossing);
					err_count++;
				end
				if (out_payload !== e.payload) begin
					$error("out_payload: expected %0d, got %0d", e.payload, out_payload);
					err_count++;
				end
				if (is_entry !== e.is_entry) begin
					$error("is_entry: expected %0b, got %0b", e.is_entry, is_entry);
					err_count++;
				end
				if (out_last !== e.last) begin
					$error("out_last: expected %0b, got %0b", e.last, out_last);
					err_count++;
				end
				if (crossings_left !== e.left) begin
					$error("crossings_left: expected %0d, got %0d", e.left, crossings_left);
					err_count++;
				end
			end
		end
	end

	// Receiver stalls
	always @(negedge clk)
		out_ready = ($urandom_range(99) >= recv_stall_pct);

	// Send one entry; called and returns at a falling edge
	task automatic send_entry(input logic [CW-1:0] c, input logic [PW-1:0] p,
			input logic l);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		entry_crossing = c;
		entry_payload = p;
		entry_last = l;
		do
			@(posedge clk);
		while (!in_ready);
		entries_sent++;
		if (l)
			codes_sent++;
		@(negedge clk);
	endtask

	// Let every result drain, then write the deleted crossing
	task automatic set_deleted(input logic [CW-1:0] v);
		in_valid = 1'b0;
		while (gauss_out_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we = 1'b1;
		cfg_data = v;
		deleted_settings++;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Well-formed code: crossings 0..n-1 each twice, shuffled
	task automatic send_gauss_code(input int n);
		int order[];
		int j;
		int t;
		order = new[2 * n];
		for (int i = 0; i < 2 * n; i++)
			order[i] = i / 2;
		for (int i = 2 * n - 1; i > 0; i--) begin
			j = $urandom_range(i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (int i = 0; i < 2 * n; i++)
			send_entry(CW'(order[i]), PW'($urandom), i == 2 * n - 1);
	endtask

	// Malformed code: random indices clustered around the deleted one
	task automatic send_noise_code(input logic [CW-1:0] d);
		int len;
		logic [CW-1:0] c;
		len = $urandom_range(1, 8);
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(3))
				0: c = CW'($urandom);
				1: c = d;
				2: c = d + 1'b1;
				default: c = d - 1'b1;
			endcase
			send_entry(c, PW'($urandom), i == len - 1);
		end
	endtask

	// Deleted crossing for a random phase: mostly small, some extremes
	function automatic logic [CW-1:0] pick_deleted();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return CW'($urandom_range(15));
		else if (r < 70)
			return TOP_INDEX;
		else if (r < 80)
			return '0;
		else
			return CW'($urandom);
	endfunction

	// Reset value of the register is crossing 0
	task automatic test_reset_value();
		send_entry(10'd1, 2'd3, 1'b0);
		send_entry(10'd0, 2'd2, 1'b0);
		send_entry(10'd1, 2'd0, 1'b0);
		send_entry(10'd0, 2'd1, 1'b1);
	endtask

	// Every entry deleted: one empty end marker per code
	task automatic test_all_deleted();
		send_entry(10'd0, 2'd1, 1'b0);
		send_entry(10'd0, 2'd2, 1'b1);
		send_entry(10'd0, 2'd3, 1'b1);
	endtask

	// Top index deleted, and a code that does not contain it
	task automatic test_extreme_indices();
		set_deleted(TOP_INDEX);
		send_entry(TOP_INDEX - 1'b1, 2'd3, 1'b0);
		send_entry(TOP_INDEX, 2'd1, 1'b0);
		send_entry(10'd0, 2'd0, 1'b0);
		send_entry(TOP_INDEX, 2'd2, 1'b1);
		send_entry(10'd0, 2'd1, 1'b0);
		send_entry(10'd1, 2'd2, 1'b0);
		send_entry(10'd0, 2'd3, 1'b0);
		send_entry(10'd1, 2'd0, 1'b1);
	endtask

	// Odd kept count rounds up; single kept entry at the top index
	task automatic test_odd_kept();
		set_deleted(10'd5);
		send_entry(10'd6, 2'd1, 1'b0);
		send_entry(10'd2, 2'd2, 1'b0);
		send_entry(10'd6, 2'd0, 1'b1);
		set_deleted(10'd0);
		send_entry(TOP_INDEX, 2'd3, 1'b1);
	endtask

	// Code longer than twice the crossing limit: kept count saturates
	task automatic test_long_code();
		logic [CW-1:0] c;
		set_deleted(10'd2);
		for (int i = 0; i < KEPT_SAT + 60; i++) begin
			c = CW'($urandom);
			if (c == 10'd2)
				c = 10'd3;
			send_entry(c, PW'($urandom), i == KEPT_SAT + 59);
		end
	endtask

	// Random codes under one idle mix, several register settings
	task automatic test_random_codes(input int idle_pct, input int stall_pct,
			input int items);
		int target;
		logic [CW-1:0] d;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int ph = 0; ph < 4; ph++) begin
			d = pick_deleted();
			set_deleted(d);
			target = entries_sent + items / 4;
			while (entries_sent < target) begin
				if ($urandom_range(99) < 70)
					send_gauss_code(($urandom_range(9) == 0) ?
						$urandom_range(17, 40) : $urandom_range(1, 16));
				else
					send_noise_code(d);
			end
		end
	endtask

	// Main sequence
	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_value();
		test_all_deleted();
		test_extreme_indices();
		test_odd_kept();
		test_long_code();
		test_random_codes(0, 0, 400);
		test_random_codes(70, 0, 400);
		test_random_codes(0, 70, 400);
		test_random_codes(11, 11, 400);
		in_valid = 1'b0;
		while (gauss_out_q.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		$display("Sent %0d entries in %0d codes under %0d deleted-crossing settings,",
			entries_sent, codes_sent, deleted_settings);
		$display("checked %0d results across four sender/receiver idle mixes.",
			results_checked);
		if (err_count == 0)
			$display("** gauss_code_crossing_delete: PASSED **");
		else
			$display("** gauss_code_crossing_delete: FAILED **");
		$finish;
	end

	// Run limit
	initial begin
		#6_000_000;
		$display("** gauss_code_crossing_delete: FAILED **");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/gcd_pkg.sv
sv/gcd_entry_proc.sv
sv/gcd_out_queue.sv
sv/gauss_code_crossing_delete.sv
tb/sv/testbench.sv
